@@ rtl/core/vbt_pkg.sv @@
// Package: shared types, constants and codes of the beam timing and IRQ generator.
`default_nettype none
package vbt_pkg;

    localparam int DOT_W   = 11;
    localparam int LINE_W  = 9;
    localparam int FC_W    = 20;
    localparam int DELTA_W = 10;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 3;

    localparam int CPL_INT = 1364;
    localparam int LPF_INT = 262;
    localparam int CPF_INT = CPL_INT * LPF_INT;

    localparam logic [DOT_W:0]   CYCLES_PER_LINE  = (DOT_W + 1)'(CPL_INT);
    localparam logic [FC_W-1:0]  FRAME_LEN        = FC_W'(CPF_INT);
    localparam logic [FC_W-1:0]  FRAME_CYCLES_RST = FC_W'(CPF_INT + 100);
    localparam logic [DOT_W-1:0] DOT_MAX          = '1;
    localparam logic [FC_W-1:0]  FC_MAX           = '1;

    localparam logic [DOT_W-1:0]  HDMA_DOT        = DOT_W'(32'h116 * 4);
    localparam logic [DOT_W-1:0]  HBLANK_DOT      = DOT_W'(32'h121 * 4);
    localparam logic [LINE_W-1:0] RENDER_LIMIT    = LINE_W'(226);
    localparam logic [LINE_W-1:0] VBLANK_LINE     = LINE_W'(225);
    localparam logic [LINE_W-1:0] VBLANK_END_POLL = LINE_W'(228);

    localparam logic [7:0] ST_VBLANK_START = 8'h81;
    localparam logic [7:0] ST_VBLANK_POLL  = 8'h80;
    localparam logic [7:0] ST_HBLANK       = 8'h40;

    // item operation codes
    localparam logic [1:0] OP_ADVANCE     = 2'd0;
    localparam logic [1:0] OP_FRAME_START = 2'd1;
    localparam logic [1:0] OP_SERVICE     = 2'd2;

    // position IRQ modes
    localparam logic [1:0] IRQ_OFF  = 2'd0;
    localparam logic [1:0] IRQ_H    = 2'd1;
    localparam logic [1:0] IRQ_V    = 2'd2;
    localparam logic [1:0] IRQ_VH   = 2'd3;

    // service kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_NMI   = 2'd2;
    localparam logic [1:0] KIND_IRQ   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NMI_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_H_TRIGGER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_V_TRIGGER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VH_TRIGGER = 3'd4;

    typedef struct packed {
        logic               nmi_enable;
        logic [1:0]         irq_mode;
        logic [DOT_W-1:0]   h_trigger;
        logic [FC_W-1:0]    v_trigger;
        logic [FC_W-1:0]    vh_trigger;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [DELTA_W-1:0] cycle_delta;
        logic               irq_disable;
    } in_item_t;

    typedef struct packed {
        logic               render_valid;
        logic [LINE_W-1:0]  render_line;
        logic               hdma_start;
        logic               frame_done;
        logic               frame_over;
        logic [7:0]         status_byte;
        logic               nmi_latched;
        logic               field;
        logic [LINE_W-1:0]  line_count;
        logic               irq_pending;
        logic               nmi_pending;
        logic [1:0]         service_kind;
    } out_item_t;

endpackage
`default_nettype wire

@@ rtl/core/vbt_cfg_regs.sv @@
// Configuration register file: NMI enable, IRQ mode and trigger positions.
`default_nettype none
module vbt_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [vbt_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [vbt_pkg::CFG_W-1:0]     cfg_wr_data,
    output vbt_pkg::cfg_t                      cfg
);

    vbt_pkg::cfg_t cfg_reg;
    vbt_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                vbt_pkg::CFG_NMI_ENABLE: cfg_next.nmi_enable = cfg_wr_data[0];
                vbt_pkg::CFG_IRQ_MODE:   cfg_next.irq_mode   = cfg_wr_data[1:0];
                vbt_pkg::CFG_H_TRIGGER:  cfg_next.h_trigger  = cfg_wr_data[vbt_pkg::DOT_W-1:0];
                vbt_pkg::CFG_V_TRIGGER:  cfg_next.v_trigger  = cfg_wr_data[vbt_pkg::FC_W-1:0];
                vbt_pkg::CFG_VH_TRIGGER: cfg_next.vh_trigger = cfg_wr_data[vbt_pkg::FC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ rtl/core/vbt_core.sv @@
// Beam counter state and single-pass next-state / result logic for one item.
`default_nettype none
module vbt_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step,
    input  vbt_pkg::in_item_t  item,
    input  vbt_pkg::cfg_t      cfg,
    output vbt_pkg::out_item_t result
);

    logic [vbt_pkg::FC_W-1:0]   frame_cycles_reg, frame_cycles_next;
    logic [vbt_pkg::DOT_W-1:0]  dot_count_reg, dot_count_next;
    logic [vbt_pkg::LINE_W-1:0] line_counter_reg, line_counter_next;
    logic [7:0]                 status_reg, status_next;
    logic line_ready_reg, line_ready_next;
    logic hdma_armed_reg, hdma_armed_next;
    logic vblank_hit_reg, vblank_hit_next;
    logic irq_spent_reg, irq_spent_next;
    logic irq_pend_reg, irq_pend_next;
    logic nmi_pend_reg, nmi_pend_next;
    logic reset_pend_reg, reset_pend_next;
    logic nmi_occurred_reg, nmi_occurred_next;
    logic field_bit_reg, field_bit_next;

    logic [vbt_pkg::FC_W:0]    fc_sum;
    logic [vbt_pkg::DOT_W:0]   dot_sum;
    logic [vbt_pkg::DOT_W:0]   dot_wrap;
    logic [1:0]                kind;
    logic                      rv, hs, fd;
    logic [vbt_pkg::LINE_W-1:0] rl;

    always_comb begin
        frame_cycles_next = frame_cycles_reg;
        dot_count_next    = dot_count_reg;
        line_counter_next = line_counter_reg;
        status_next       = status_reg;
        line_ready_next   = line_ready_reg;
        hdma_armed_next   = hdma_armed_reg;
        vblank_hit_next   = vblank_hit_reg;
        irq_spent_next    = irq_spent_reg;
        irq_pend_next     = irq_pend_reg;
        nmi_pend_next     = nmi_pend_reg;
        reset_pend_next   = reset_pend_reg;
        nmi_occurred_next = nmi_occurred_reg;
        field_bit_next    = field_bit_reg;
        rv   = 1'b0;
        rl   = '0;
        hs   = 1'b0;
        fd   = 1'b0;
        kind = vbt_pkg::KIND_NONE;
        fc_sum   = {1'b0, frame_cycles_reg}
                 + (vbt_pkg::FC_W + 1)'(item.cycle_delta);
        dot_sum  = {1'b0, dot_count_reg} + (vbt_pkg::DOT_W + 1)'(item.cycle_delta);
        dot_wrap = dot_sum - vbt_pkg::CYCLES_PER_LINE;

        case (item.op)
            vbt_pkg::OP_ADVANCE: begin
                frame_cycles_next = fc_sum[vbt_pkg::FC_W] ? vbt_pkg::FC_MAX
                                                          : fc_sum[vbt_pkg::FC_W-1:0];
                if (dot_sum >= vbt_pkg::CYCLES_PER_LINE) begin
                    dot_count_next = dot_wrap[vbt_pkg::DOT_W] ? vbt_pkg::DOT_MAX
                                                              : dot_wrap[vbt_pkg::DOT_W-1:0];
                    // line step
                    line_counter_next = line_counter_reg + vbt_pkg::LINE_W'(1);
                    if (line_counter_next < vbt_pkg::RENDER_LIMIT) begin
                        line_ready_next = 1'b1;
                    end
                    if (line_counter_next < vbt_pkg::VBLANK_LINE) begin
                        hdma_armed_next = 1'b1;
                    end
                    vblank_hit_next = (line_counter_next == vbt_pkg::VBLANK_LINE);
                    if (line_counter_next == vbt_pkg::VBLANK_LINE) begin
                        status_next = vbt_pkg::ST_VBLANK_START;
                    end
                    if (line_counter_next == vbt_pkg::VBLANK_END_POLL) begin
                        status_next = vbt_pkg::ST_VBLANK_POLL;
                    end
                    status_next = status_next & ~vbt_pkg::ST_HBLANK;
                    if (cfg.irq_mode == vbt_pkg::IRQ_H) begin
                        irq_spent_next = 1'b0;
                    end
                end else begin
                    dot_count_next = dot_sum[vbt_pkg::DOT_W-1:0];
                end
                if (line_ready_next) begin
                    rv = 1'b1;
                    rl = line_counter_next - vbt_pkg::LINE_W'(1);
                    line_ready_next = 1'b0;
                end
                if (hdma_armed_next && dot_count_next > vbt_pkg::HDMA_DOT) begin
                    hs = 1'b1;
                    hdma_armed_next = 1'b0;
                end
                if (dot_count_next >= vbt_pkg::HBLANK_DOT) begin
                    status_next = status_next | vbt_pkg::ST_HBLANK;
                end
                if (vblank_hit_next) begin
                    fd = 1'b1;
                    vblank_hit_next = 1'b0;
                    if (cfg.nmi_enable) begin
                        nmi_pend_next = 1'b1;
                    end
                    nmi_occurred_next = 1'b1;
                    field_bit_next = ~field_bit_reg;
                end
                // position IRQ
                if (!irq_spent_next) begin
                    if ((cfg.irq_mode == vbt_pkg::IRQ_V
                         && frame_cycles_next >= cfg.v_trigger)
                        || (cfg.irq_mode == vbt_pkg::IRQ_H
                            && dot_count_next >= cfg.h_trigger)
                        || (cfg.irq_mode == vbt_pkg::IRQ_VH
                            && frame_cycles_next >= cfg.vh_trigger)) begin
                        irq_pend_next = 1'b1;
                    end
                    if (item.irq_disable && irq_pend_next) begin
                        irq_pend_next  = 1'b0;
                        irq_spent_next = 1'b1;
                    end
                end
            end
            vbt_pkg::OP_FRAME_START: begin
                frame_cycles_next = (frame_cycles_reg >= vbt_pkg::FRAME_LEN)
                                  ? frame_cycles_reg - vbt_pkg::FRAME_LEN : '0;
                line_counter_next = '0;
                dot_count_next    = '0;
                nmi_occurred_next = 1'b0;
                hdma_armed_next   = 1'b0;
                status_next       = '0;
                irq_spent_next    = 1'b0;
            end
            vbt_pkg::OP_SERVICE: begin
                if (reset_pend_reg) begin
                    reset_pend_next = 1'b0;
                    kind = vbt_pkg::KIND_RESET;
                end else if (nmi_pend_reg) begin
                    nmi_pend_next = 1'b0;
                    kind = vbt_pkg::KIND_NMI;
                end else if (irq_pend_reg) begin
                    irq_pend_next  = 1'b0;
                    irq_spent_next = 1'b1;
                    kind = vbt_pkg::KIND_IRQ;
                end
            end
            default: ;
        endcase

        result.render_valid = rv;
        result.render_line  = rl;
        result.hdma_start   = hs;
        result.frame_done   = fd;
        result.frame_over   = (frame_cycles_next >= vbt_pkg::FRAME_LEN);
        result.status_byte  = status_next;
        result.nmi_latched  = nmi_occurred_next;
        result.field        = field_bit_next;
        result.line_count   = line_counter_next;
        result.irq_pending  = irq_pend_next;
        result.nmi_pending  = nmi_pend_next;
        result.service_kind = kind;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_cycles_reg <= vbt_pkg::FRAME_CYCLES_RST;
            dot_count_reg    <= '0;
            line_counter_reg <= '0;
            status_reg       <= '0;
            line_ready_reg   <= 1'b0;
            hdma_armed_reg   <= 1'b0;
            vblank_hit_reg   <= 1'b0;
            irq_spent_reg    <= 1'b0;
            irq_pend_reg     <= 1'b0;
            nmi_pend_reg     <= 1'b0;
            reset_pend_reg   <= 1'b1;
            nmi_occurred_reg <= 1'b0;
            field_bit_reg    <= 1'b0;
        end else if (step) begin
            frame_cycles_reg <= frame_cycles_next;
            dot_count_reg    <= dot_count_next;
            line_counter_reg <= line_counter_next;
            status_reg       <= status_next;
            line_ready_reg   <= line_ready_next;
            hdma_armed_reg   <= hdma_armed_next;
            vblank_hit_reg   <= vblank_hit_next;
            irq_spent_reg    <= irq_spent_next;
            irq_pend_reg     <= irq_pend_next;
            nmi_pend_reg     <= nmi_pend_next;
            reset_pend_reg   <= reset_pend_next;
            nmi_occurred_reg <= nmi_occurred_next;
            field_bit_reg    <= field_bit_next;
        end
    end

    // reset request is taken once and never returns
    a_reset_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !reset_pend_reg |=> !reset_pend_reg)
        else $error("reset request reappeared");

    // a spent IRQ is never still pending
    a_irq_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(irq_pend_reg && irq_spent_reg))
        else $error("IRQ both pending and spent");

    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && item.op == vbt_pkg::OP_FRAME_START)
        |=> (line_counter_reg == '0 && dot_count_reg == '0 && status_reg == '0))
        else $error("frame start did not rebase counters");

    a_nmi_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && item.op == vbt_pkg::OP_SERVICE && result.service_kind == vbt_pkg::KIND_NMI)
        |=> !nmi_pend_reg)
        else $error("NMI still pending after service");

endmodule
`default_nettype wire

@@ rtl/core/video_beam_timing_irq_gen.sv @@
// Top level: input register, beam timing core, config registers and result register.
//
// One item per clock while the output is taken: an accepted item sits in the
// input register, the core computes the beam counter and interrupt state
// update from it and the result lands in the output register. Throughput is
// one item per cycle while m_ready holds; s_ready stays high while the input
// register is empty or the result register is empty or is taken in the same
// cycle. Configuration writes are registered and should be made while no
// item is in flight.
`default_nettype none
module video_beam_timing_irq_gen (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output      logic                          s_ready,
    input  vbt_pkg::in_item_t                  s_data,
    output      logic                          m_valid,
    input  wire logic                          m_ready,
    output vbt_pkg::out_item_t                 m_data,
    input  wire logic                          cfg_wr_en,
    input  wire logic [vbt_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [vbt_pkg::CFG_W-1:0]     cfg_wr_data
);

    logic               in_valid_reg, in_valid_next;
    vbt_pkg::in_item_t  in_item_reg;
    logic               out_valid_reg, out_valid_next;
    vbt_pkg::out_item_t out_item_reg;
    vbt_pkg::out_item_t core_result;
    vbt_pkg::cfg_t      cfg;
    logic               step;

    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (step) begin
            out_item_reg <= core_result;
        end
    end

    vbt_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    vbt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

endmodule
`default_nettype wire
